/* sv/ctc_pkg.sv */
// Shared constants and beat types for the counter/timer channel block.
`timescale 1ns / 1ps

package ctc_pkg;

   // Channel count and the index width that follows from it
   localparam int NUM_CHANNELS = 8;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int GROUP_SIZE   = 4;

   // Input beat modes
   localparam logic MODE_WRITE   = 1'b0;
   localparam logic MODE_TRIGGER = 1'b1;

   // Control word bits and vector mask
   localparam logic [7:0] TIME_FOLLOWS_BIT = 8'h04;
   localparam logic [7:0] INT_ENABLE_BIT   = 8'h80;
   localparam logic [7:0] VECTOR_MASK      = 8'hf8;

   typedef struct packed {
      logic       mode;
      logic [2:0] channel;
      logic [7:0] data;
   } req_payload_type;

   typedef struct packed {
      logic       irq_valid;
      logic [7:0] irq_vector;
      logic [2:0] irq_channel;
   } rsp_payload_type;

endpackage

/* sv/counter_timer_channels_core.sv */
// Counter/timer channel block: eight-bit down counters in groups of four.
//
// Path: an accepted req beat goes through the input register, then the channel
//    update and result register. Throughput: one beat per cycle while the skid
//    entry is free; each beat touches one channel (or one group of four for a
//    vector write) through a single register-to-register pass.
// Reset: synchronous; clears all control words, time constants, counters and
//    vectors to zero and empties the pipeline.
`timescale 1ns / 1ps

module counter_timer_channels_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ctc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ctc_pkg::rsp_payload_type rsp_payload
);

   // Input register
   logic                     s1_valid_ff;
   ctc_pkg::req_payload_type s1_pl_ff;

   // Output register plus skid entry
   logic                     out_valid_ff;
   ctc_pkg::rsp_payload_type out_pl_ff;
   logic                     skid_valid_ff;
   ctc_pkg::rsp_payload_type skid_pl_ff;

   // Channel state
   logic [7:0] ctrl_ff  [ctc_pkg::NUM_CHANNELS];
   logic [7:0] tc_ff    [ctc_pkg::NUM_CHANNELS];
   logic [7:0] count_ff [ctc_pkg::NUM_CHANNELS];
   logic [7:0] vec_ff   [ctc_pkg::NUM_CHANNELS];
   logic [7:0] ctrl_in  [ctc_pkg::NUM_CHANNELS];
   logic [7:0] tc_in    [ctc_pkg::NUM_CHANNELS];
   logic [7:0] count_in [ctc_pkg::NUM_CHANNELS];
   logic [7:0] vec_in   [ctc_pkg::NUM_CHANNELS];

   logic                        req_take;
   logic                        out_pop;
   logic                        s1_adv;
   logic                        ch_ok;
   logic [ctc_pkg::CH_IDX_W-1:0] sel;
   logic [7:0]                  sel_ctrl;
   logic [7:0]                  sel_count;
   logic [7:0]                  count_dec;
   logic                        hit_zero;
   logic                        do_write;
   logic                        do_tick;
   logic                        wr_tc;
   logic                        wr_ctrl;
   logic                        wr_vec;
   ctc_pkg::rsp_payload_type    result;

   // Handshake: stage 1 moves on whenever the skid entry is free
   assign s1_adv    = s1_valid_ff && !skid_valid_ff;
   assign req_stall = s1_valid_ff && skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_pop   = out_valid_ff && !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_pl_ff;

   // Selected channel's state
   assign ch_ok     = 32'(s1_pl_ff.channel) < ctc_pkg::NUM_CHANNELS;
   assign sel       = ctc_pkg::CH_IDX_W'(s1_pl_ff.channel);
   assign sel_ctrl  = ctrl_ff[sel];
   assign sel_count = count_ff[sel];
   assign count_dec = sel_count - 8'd1;
   assign hit_zero  = (count_dec == 8'd0);

   // Decode the beat
   assign do_write = s1_adv && ch_ok && (s1_pl_ff.mode == ctc_pkg::MODE_WRITE);
   assign do_tick  = s1_adv && ch_ok && (s1_pl_ff.mode == ctc_pkg::MODE_TRIGGER);
   assign wr_tc    = do_write && ((sel_ctrl & ctc_pkg::TIME_FOLLOWS_BIT) != 8'd0);
   assign wr_ctrl  = do_write && !wr_tc && s1_pl_ff.data[0];
   assign wr_vec   = do_write && !wr_tc && !s1_pl_ff.data[0];

   // Result of the beat
   always_comb begin
      result = '0;
      if (do_tick && hit_zero && ((sel_ctrl & ctc_pkg::INT_ENABLE_BIT) != 8'd0)) begin
         result.irq_valid   = 1'b1;
         result.irq_vector  = vec_ff[sel];
         result.irq_channel = s1_pl_ff.channel;
      end
   end

   // Next state per channel
   always_comb begin
      for (int i = 0; i < ctc_pkg::NUM_CHANNELS; i++) begin
         ctrl_in[i]  = ctrl_ff[i];
         tc_in[i]    = tc_ff[i];
         count_in[i] = count_ff[i];
         vec_in[i]   = vec_ff[i];
         if (32'(sel) == i) begin
            if (wr_tc) begin
               tc_in[i]   = s1_pl_ff.data;
               ctrl_in[i] = ctrl_ff[i] & ~ctc_pkg::TIME_FOLLOWS_BIT;
               if (count_ff[i] == 8'd0) begin
                  count_in[i] = s1_pl_ff.data;
               end
            end else if (wr_ctrl) begin
               ctrl_in[i] = s1_pl_ff.data;
            end else if (do_tick) begin
               count_in[i] = hit_zero ? tc_ff[i] : count_dec;
            end
         end
         // Vector write covers the whole group of the addressed channel
         if (wr_vec && ((i / ctc_pkg::GROUP_SIZE) ==
                        (32'(s1_pl_ff.channel) / ctc_pkg::GROUP_SIZE))) begin
            vec_in[i] = (s1_pl_ff.data & ctc_pkg::VECTOR_MASK) |
                        8'((i % ctc_pkg::GROUP_SIZE) << 1);
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < ctc_pkg::NUM_CHANNELS; i++) begin
         if (reset) begin
            ctrl_ff[i]  <= '0;
            tc_ff[i]    <= '0;
            count_ff[i] <= '0;
            vec_ff[i]   <= '0;
         end else begin
            ctrl_ff[i]  <= ctrl_in[i];
            tc_ff[i]    <= tc_in[i];
            count_ff[i] <= count_in[i];
            vec_ff[i]   <= vec_in[i];
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_take) begin
         s1_pl_ff <= req_payload;
      end
   end

   // Output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_pop) begin
            out_pl_ff     <= skid_pl_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (s1_adv) begin
         if (!out_valid_ff || out_pop) begin
            out_valid_ff <= 1'b1;
            out_pl_ff    <= result;
         end else begin
            skid_valid_ff <= 1'b1;
            skid_pl_ff    <= result;
         end
      end else if (out_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A quiet result beat carries no vector or channel
   a_quiet_result: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pl_ff.irq_valid) |->
         (out_pl_ff.irq_vector == 8'd0 && out_pl_ff.irq_channel == 3'd0))
      else $error("result without interrupt carries data");

   // Input side only stalls with an item waiting in the input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && skid_valid_ff && out_valid_ff))
      else $error("input stalled without a full pipeline");

   // A time constant write clears the time-follows bit of its channel
   a_tc_clears_follow: assert property (@(posedge clock) disable iff (reset)
      wr_tc |=> ((ctrl_ff[$past(sel)] & ctc_pkg::TIME_FOLLOWS_BIT) == 8'd0))
      else $error("time-follows bit still set after time constant write");

endmodule

/* bench/ctc_irq_checker.sv */
// Watches all channels, predicts each result beat and compares it field by field.
`timescale 1ns / 1ps

module ctc_irq_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  ctc_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  ctc_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       irq_seen
);

   // Shadow of the per-channel registers
   logic [7:0] ctrl_word      [ctc_pkg::NUM_CHANNELS];
   logic [7:0] reload_value   [ctc_pkg::NUM_CHANNELS];
   logic [7:0] count_value    [ctc_pkg::NUM_CHANNELS];
   logic [7:0] irq_vector_reg [ctc_pkg::NUM_CHANNELS];

   // Results still owed by the block, oldest first
   ctc_pkg::rsp_payload_type expected_irq_q [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Applies one accepted input beat to the shadow registers and returns its result
   function automatic ctc_pkg::rsp_payload_type apply_beat(ctc_pkg::req_payload_type beat);
      ctc_pkg::rsp_payload_type res;
      int ch;
      int base;
      res = '0;
      ch  = int'(beat.channel);
      if (ch >= ctc_pkg::NUM_CHANNELS) return res;
      if (beat.mode == ctc_pkg::MODE_WRITE) begin
         if ((ctrl_word[ch] & ctc_pkg::TIME_FOLLOWS_BIT) != 8'h00) begin
            // time constant: counter picks it up only when sitting at zero
            reload_value[ch] = beat.data;
            if (count_value[ch] == 8'h00) count_value[ch] = beat.data;
            ctrl_word[ch] = ctrl_word[ch] & ~ctc_pkg::TIME_FOLLOWS_BIT;
         end else if (beat.data[0]) begin
            ctrl_word[ch] = beat.data;
         end else begin
            // vector goes to every existing channel of the group
            base = ch - (ch % ctc_pkg::GROUP_SIZE);
            for (int k = 0; k < ctc_pkg::GROUP_SIZE; k++) begin
               if (base + k < ctc_pkg::NUM_CHANNELS)
                  irq_vector_reg[base + k] = (beat.data & ctc_pkg::VECTOR_MASK) |
                                             8'(k << 1);
            end
         end
      end else begin
         // tick: wrap-around decrement, reload and maybe interrupt on zero
         count_value[ch] = count_value[ch] - 8'd1;
         if (count_value[ch] == 8'h00) begin
            count_value[ch] = reload_value[ch];
            if ((ctrl_word[ch] & ctc_pkg::INT_ENABLE_BIT) != 8'h00) begin
               res.irq_valid   = 1'b1;
               res.irq_vector  = irq_vector_reg[ch];
               res.irq_channel = beat.channel;
            end
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      ctc_pkg::rsp_payload_type want;
      if (reset) begin
         for (int i = 0; i < ctc_pkg::NUM_CHANNELS; i++) begin
            ctrl_word[i]      = 8'h00;
            reload_value[i]   = 8'h00;
            count_value[i]    = 8'h00;
            irq_vector_reg[i] = 8'h00;
         end
         expected_irq_q.delete();
         mismatch_count = 0;
         irq_seen       = 0;
      end else begin
         if (req_valid && !req_stall) expected_irq_q.push_back(apply_beat(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_irq_q.size() == 0) begin
               report_mismatch("result beat with nothing expected", 32'(rsp_payload),
                               32'd0);
            end else begin
               want = expected_irq_q.pop_front();
               if (rsp_payload.irq_valid != want.irq_valid)
                  report_mismatch("irq_valid", 32'(rsp_payload.irq_valid),
                                  32'(want.irq_valid));
               if (rsp_payload.irq_vector != want.irq_vector)
                  report_mismatch("irq_vector", 32'(rsp_payload.irq_vector),
                                  32'(want.irq_vector));
               if (rsp_payload.irq_channel != want.irq_channel)
                  report_mismatch("irq_channel", 32'(rsp_payload.irq_channel),
                                  32'(want.irq_channel));
            end
            if (rsp_payload.irq_valid) irq_seen++;
         end
      end
      pending_count = expected_irq_q.size();
   end

endmodule

/* bench/tb.sv */
// Stimulus, flow control and verdict for the counter/timer channel block.
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT   = 1000;  // cycles with no beat on either side
   localparam int LONG_HOLD    = 80;    // receiver hold-off to back up the block
   localparam int HOLD_AT_BEAT = 300;
   localparam int TARGET_BEATS = 1000;
   localparam int DRAIN_CYCLES = 8;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_valid   = 1'b0;
   logic                     req_stall;
   ctc_pkg::req_payload_type req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_stall   = 1'b0;
   ctc_pkg::rsp_payload_type rsp_payload;

   int mismatch_count;
   int pending_count;
   int irq_seen;

   int beats_sent         = 0;
   int writes_sent        = 0;
   int ticks_sent         = 0;
   int input_stall_cycles = 0;
   int idle_cycles        = 0;
   bit sender_quiet       = 1'b0;

   int rsp_taken = 0;
   int rsp_wait  = 0;
   bit rsp_quiet = 1'b0;

   always #2 clock = ~clock;

   counter_timer_channels_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   ctc_irq_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .irq_seen       (irq_seen)
   );

   // One input beat: random gap, then hold until accepted
   task automatic send_beat(input logic beat_mode, input logic [2:0] beat_ch,
                            input logic [7:0] beat_data);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{mode: beat_mode, channel: beat_ch, data: beat_data};
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (beat_mode == ctc_pkg::MODE_WRITE) writes_sent++;
      else ticks_sent++;
      if (beats_sent % 40 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
   endtask

   // Mostly well-formed channel programs; some noise and broken programs
   task automatic run_channel_sequence();
      int pick;
      int c;
      int n;
      logic [7:0] ctrl;
      logic [7:0] tc;
      pick = $urandom_range(0, 9);
      c    = $urandom_range(0, 7);
      if (pick < 7) begin
         ctrl = 8'($urandom_range(0, 255)) | ctc_pkg::TIME_FOLLOWS_BIT | 8'h01;
         if ($urandom_range(0, 3) != 0) ctrl = ctrl | ctc_pkg::INT_ENABLE_BIT;
         send_beat(ctc_pkg::MODE_WRITE, 3'(c), ctrl);
         n  = $urandom_range(0, 9);
         tc = (n < 8) ? 8'($urandom_range(1, 6)) :
              (n == 8) ? 8'h00 : 8'($urandom_range(0, 255));
         send_beat(ctc_pkg::MODE_WRITE, 3'(c), tc);
         if ($urandom_range(0, 2) == 0)
            send_beat(ctc_pkg::MODE_WRITE, 3'(c), 8'($urandom_range(0, 255)) & 8'hfe);
         repeat ($urandom_range(1, 12))
            send_beat(ctc_pkg::MODE_TRIGGER, 3'(c), 8'($urandom_range(0, 255)));
      end else if (pick < 9) begin
         repeat ($urandom_range(1, 4))
            send_beat(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)));
      end else begin
         // control asks for a constant, ticks come first instead
         send_beat(ctc_pkg::MODE_WRITE, 3'(c),
                   8'($urandom_range(0, 255)) | ctc_pkg::TIME_FOLLOWS_BIT | 8'h01);
         repeat ($urandom_range(1, 4))
            send_beat(ctc_pkg::MODE_TRIGGER, 3'(c), 8'($urandom_range(0, 255)));
      end
   endtask

   // Receiver: random hold per beat, quiet stretches, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
            if (rsp_taken % 64 == 0) rsp_quiet = ($urandom_range(0, 2) == 0);
            if (rsp_taken == HOLD_AT_BEAT) rsp_wait = LONG_HOLD;
            else rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 3);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on beats moving in either direction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: tick at zero wraps, vector and control writes, reload cases
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd0, 8'hff);
      send_beat(ctc_pkg::MODE_WRITE,   3'd0, 8'h00);
      send_beat(ctc_pkg::MODE_WRITE,   3'd2, 8'hff);
      send_beat(ctc_pkg::MODE_WRITE,   3'd2, 8'h01);
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd2, 8'h00);
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd2, 8'h55);
      send_beat(ctc_pkg::MODE_WRITE,   3'd3, 8'h81);
      send_beat(ctc_pkg::MODE_WRITE,   3'd6, 8'hfe);
      send_beat(ctc_pkg::MODE_WRITE,   3'd7, 8'h85);
      send_beat(ctc_pkg::MODE_WRITE,   3'd7, 8'h03);
      // constant written while counting: counter keeps its value
      send_beat(ctc_pkg::MODE_WRITE,   3'd7, 8'h85);
      send_beat(ctc_pkg::MODE_WRITE,   3'd7, 8'h02);
      repeat (3) send_beat(ctc_pkg::MODE_TRIGGER, 3'd7, 8'haa);
      send_beat(ctc_pkg::MODE_WRITE,   3'd1, 8'h05);
      send_beat(ctc_pkg::MODE_WRITE,   3'd1, 8'h01);
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd1, 8'h0f);
      send_beat(ctc_pkg::MODE_WRITE,   3'd4, 8'h87);
      send_beat(ctc_pkg::MODE_WRITE,   3'd4, 8'h00);
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd4, 8'hf0);
      send_beat(ctc_pkg::MODE_WRITE,   3'd3, 8'haa);
      send_beat(ctc_pkg::MODE_TRIGGER, 3'd3, 8'h33);

      // Constant of zero: a full 256-tick period from a counter still at zero
      send_beat(ctc_pkg::MODE_WRITE, 3'd5, 8'h85);
      send_beat(ctc_pkg::MODE_WRITE, 3'd5, 8'h00);
      repeat (256) send_beat(ctc_pkg::MODE_TRIGGER, 3'd5, 8'($urandom_range(0, 255)));

      while (beats_sent < TARGET_BEATS) run_channel_sequence();
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d beats (%0d writes, %0d ticks) and %0d interrupts",
               beats_sent, writes_sent, ticks_sent, irq_seen);
      $display("input held off for %0d cycles, one receiver hold of %0d cycles",
               input_stall_cycles, LONG_HOLD);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
